FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/scf_pkg.sv
// Types and constants of the string compare engine.
package scf_pkg;

   localparam int LenWidth  = 16;
   localparam int AddrWidth = 32;
   localparam int ByteWidth = 8;

   localparam logic ActStart = 1'b0;
   localparam logic ActData  = 1'b1;

   // Input tuser, lowest bit first: action, three_operand.
   typedef struct packed {
      logic three_operand;
      logic action;
   } req_user_type;

   // Input tdata, lowest bits first.
   typedef struct packed {
      logic [ByteWidth-1:0] second_byte;
      logic [ByteWidth-1:0] first_byte;
      logic [ByteWidth-1:0] fill_byte;
      logic [AddrWidth-1:0] second_addr;
      logic [LenWidth-1:0]  second_len;
      logic [AddrWidth-1:0] first_addr;
      logic [LenWidth-1:0]  first_len;
   } req_data_type;

   // Result tdata, lowest bits first; two zero bits fill up the last byte.
   typedef struct packed {
      logic [1:0]           pad;
      logic                 flag_c;
      logic                 flag_z;
      logic                 flag_n;
      logic [AddrWidth-1:0] second_ptr;
      logic [LenWidth-1:0]  second_left;
      logic [AddrWidth-1:0] first_ptr;
      logic [LenWidth-1:0]  first_left;
      logic                 need_second;
      logic                 need_first;
      logic                 done_res;
   } rsp_data_type;

   // Handshake between the pipeline stages.
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

FILE: hw/rtl/scf_in_stage.sv
// Input register stage of the string compare engine.
module scf_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  scf_pkg::req_user_type req_tuser,
   input  scf_pkg::req_data_type req_tdata,
   input  logic                  advance,
   output logic                  req_tready,
   output scf_pkg::stage_ctl_type ctl,
   output scf_pkg::req_user_type user,
   output scf_pkg::req_data_type data
);

   logic                  valid_ff, valid_in;
   scf_pkg::req_user_type user_ff;
   scf_pkg::req_data_type data_ff;

   // The stage frees itself in the same cycle that its word moves on.
   assign req_tready = !valid_ff || advance;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         user_ff <= req_tuser;
         data_ff <= req_tdata;
      end
   end

   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;
   assign user        = user_ff;
   assign data        = data_ff;

endmodule

FILE: hw/rtl/scf_engine.sv
// Compare state registers and the per-word update logic.
module scf_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  scf_pkg::stage_ctl_type ctl,
   input  scf_pkg::req_user_type  user,
   input  scf_pkg::req_data_type  data,
   output scf_pkg::rsp_data_type  result
);

   logic                            active_ff, active_in;
   logic [scf_pkg::LenWidth-1:0]    left1_ff, left1_in, left2_ff, left2_in;
   logic [scf_pkg::AddrWidth-1:0]   ptr1_ff, ptr1_in, ptr2_ff, ptr2_in;
   logic [scf_pkg::ByteWidth-1:0]   fill_ff, fill_in;
   logic                            cn_ff, cn_in, cz_ff, cz_in, cc_ff, cc_in;
   logic [scf_pkg::ByteWidth-1:0]   b1, b2;
   logic [scf_pkg::LenWidth-1:0]    len2;
   logic                            fire;

   assign fire = ctl.valid && ctl.advance;
   assign len2 = user.three_operand ? data.first_len : data.second_len;
   assign b1   = (left1_ff != '0) ? data.first_byte  : fill_ff;
   assign b2   = (left2_ff != '0) ? data.second_byte : fill_ff;

   always_comb begin
      active_in = active_ff;
      left1_in  = left1_ff;
      left2_in  = left2_ff;
      ptr1_in   = ptr1_ff;
      ptr2_in   = ptr2_ff;
      fill_in   = fill_ff;
      cn_in     = cn_ff;
      cz_in     = cz_ff;
      cc_in     = cc_ff;
      if (fire) begin
         if (user.action == scf_pkg::ActStart) begin
            left1_in  = data.first_len;
            left2_in  = len2;
            ptr1_in   = data.first_addr;
            ptr2_in   = data.second_addr;
            fill_in   = user.three_operand ? '0 : data.fill_byte;
            active_in = (data.first_len != '0) || (len2 != '0);
            if (!active_in) begin
               cn_in = 1'b0;
               cz_in = 1'b1;
               cc_in = 1'b0;
            end
         end else if (active_ff) begin
            if (b1 != b2) begin
               cn_in     = $signed(b1) < $signed(b2);
               cz_in     = 1'b0;
               cc_in     = b1 < b2;
               active_in = 1'b0;
            end else begin
               // An exhausted string stays put while the other one advances.
               if (left1_ff != '0) begin
                  left1_in = left1_ff - 1'b1;
                  ptr1_in  = ptr1_ff + 1'b1;
               end
               if (left2_ff != '0) begin
                  left2_in = left2_ff - 1'b1;
                  ptr2_in  = ptr2_ff + 1'b1;
               end
               if ((left1_in == '0) && (left2_in == '0)) begin
                  cn_in     = 1'b0;
                  cz_in     = 1'b1;
                  cc_in     = 1'b0;
                  active_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left1_ff  <= '0;
         left2_ff  <= '0;
         ptr1_ff   <= '0;
         ptr2_ff   <= '0;
         fill_ff   <= '0;
         cn_ff     <= 1'b0;
         cz_ff     <= 1'b1;
         cc_ff     <= 1'b0;
      end else begin
         active_ff <= active_in;
         left1_ff  <= left1_in;
         left2_ff  <= left2_in;
         ptr1_ff   <= ptr1_in;
         ptr2_ff   <= ptr2_in;
         fill_ff   <= fill_in;
         cn_ff     <= cn_in;
         cz_ff     <= cz_in;
         cc_ff     <= cc_in;
      end
   end

   // The result word reports the state as it stands after this word.
   always_comb begin
      result.pad         = '0;
      result.done_res    = !active_in;
      result.need_first  = active_in && (left1_in != '0);
      result.need_second = active_in && (left2_in != '0);
      result.first_left  = left1_in;
      result.first_ptr   = ptr1_in;
      result.second_left = left2_in;
      result.second_ptr  = ptr2_in;
      result.flag_n      = !active_in && cn_in;
      result.flag_z      = !active_in && cz_in;
      result.flag_c      = !active_in && cc_in;
   end

endmodule

FILE: hw/rtl/scf_out_stage.sv
// Result register of the string compare engine.
module scf_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  scf_pkg::rsp_data_type result,
   input  logic                  load,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output scf_pkg::rsp_data_type rsp_tdata,
   output logic                  free
);

   logic                  valid_ff, valid_in;
   scf_pkg::rsp_data_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

FILE: hw/rtl/string_compare_with_fill.sv
// Top level of the byte-string compare engine with fill byte.
//
// Words arrive on the req_ stream. A start word (action 0) loads both
// lengths, both addresses and the fill byte; with three_operand set the
// first length serves both strings and the fill byte is zero. A data
// word (action 1) carries the bytes fetched at the addresses that the
// previous result reported. Every word returns exactly one result word
// on the rsp_ stream with the updated lengths, addresses, the
// need_first and need_second fetch requests, and, once done_res is set,
// the N, Z and C flags. Memory access is done by the user of the block.
// From acceptance to rsp_tvalid a word passes the input register, then
// the compare and update logic feeding the result register. Throughput
// is one word per cycle while rsp_tready is high.
// Reset empties both stages, leaves the engine idle with zero lengths
// and addresses and Z set. When rsp_tready is low the result is held;
// one further word is taken into the input register, then req_tready
// drops until the result is taken.
module string_compare_with_fill (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tuser: action, three_operand
   input  scf_pkg::req_user_type req_tuser,
   // tdata: first_len, first_addr, second_len, second_addr, fill_byte,
   //        first_byte, second_byte
   input  scf_pkg::req_data_type req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: done_res, need_first, need_second, first_left, first_ptr,
   //        second_left, second_ptr, flag_n, flag_z, flag_c, two zero bits
   output scf_pkg::rsp_data_type rsp_tdata
);

   scf_pkg::stage_ctl_type ctl;
   scf_pkg::req_user_type  user;
   scf_pkg::req_data_type  data;
   scf_pkg::rsp_data_type  result;
   logic                   out_free;
   logic                   advance;

   assign advance = ctl.valid && out_free;

   scf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .req_tready (req_tready),
      .ctl        (ctl),
      .user       (user),
      .data       (data)
   );

   scf_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .user   (user),
      .data   (data),
      .result (result)
   );

   scf_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .load       (advance),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .free       (out_free)
   );

endmodule

FILE: hw/rtl/scf_checker.sv
// Port-level checks of the string compare engine, bound to its top level.
`include "assert_macros.svh"

module scf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input scf_pkg::rsp_data_type rsp_tdata
);

   logic rsp_stall;
   logic rsp_done;
   logic rsp_busy;
   logic no_fetch;
   logic no_flags;
   logic any_fetch;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_done  = rsp_tvalid && rsp_tdata.done_res;
   assign rsp_busy  = rsp_tvalid && !rsp_tdata.done_res;
   assign no_fetch  = !rsp_tdata.need_first && !rsp_tdata.need_second;
   assign no_flags  = !rsp_tdata.flag_n && !rsp_tdata.flag_z && !rsp_tdata.flag_c;
   assign any_fetch = rsp_tdata.need_first || rsp_tdata.need_second;

   `ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_stall, rsp_tvalid, "result word dropped")
   `ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_stall, $stable(rsp_tdata), "result word changed")
   `ASSERT_IMPL(a_done_no_fetch, clock, reset, rsp_done, no_fetch, "fetch requested after the end")
   `ASSERT_IMPL(a_busy_no_flags, clock, reset, rsp_busy, no_flags, "flags shown while running")
   `ASSERT_IMPL(a_busy_fetch, clock, reset, rsp_busy, any_fetch, "running compare requests no byte")

endmodule

bind string_compare_with_fill scf_checker u_scf_checker (.*);
